// ===== rtl/sorted_max_priority_queue_top_defines.svh =====
// Assertion macros shared by the sorted max priority queue RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_MAX_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SMPQ_CHECK(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property where a condition implies a consequence in the same cycle.
`define SMPQ_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smpq_pkg.sv =====
// Package for the sorted max priority queue: sizes, codes and shared types.
// No dependencies; imported by every module of the block.
package smpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    // Operation codes carried on the input tuser.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Status codes carried on the output tuser.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    // One finished result handed from the sequencer to the output stage.
    typedef struct packed {
        t_data                taken_value;
        t_data                top_value;
        logic [CNT_W-1:0]     entry_count;
        logic [STATUS_W-1:0]  status;
    } t_result;

    // Access to the entry store: one write and one registered read per cycle.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        t_data             wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

// ===== rtl/sorted_max_priority_queue_top.sv =====
// Top level of the sorted max priority queue: stream ports and output register.
// Depends on smpq_pkg and smpq_seq.
//
//  Channel   Dir  Handshake           Payload
//  s_*       in   i_s_tvalid/o_s_tready  tdata: value[31:0]; tuser: operation[0]
//  m_*       out  o_m_tvalid/i_m_tready  tdata: taken, top, count; tuser: status
//
// An insert walks from the tail toward the head, moving one entry per step through
// the single store write port until the value lands; an extract takes the head and
// moves each remaining entry up; rejected operations go straight to the result.
// Reset (synchronous, active low) empties the queue; the store needs no clearing.
// No word is taken while reset is held.
// A stalled result holds in the output register while the next word is taken.
module sorted_max_priority_queue_top
    import smpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [0:0]  i_s_tuser,   // [0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [31:0] taken_value, [63:32] top_value,
                                     // [68:64] entry_count, [71:69] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic    seq_idle;
    logic    res_valid;
    logic    res_ready;
    logic    start;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign o_s_tready = seq_idle && i_rst_n;
    assign start      = i_s_tvalid && o_s_tready;
    assign res_ready  = !r_out_valid || i_m_tready;

    smpq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_s_tuser[0]),
        .i_value     (i_s_tdata),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, COUNT_OUT_W'(r_out.entry_count),
                         r_out.top_value, r_out.taken_value};
    assign o_m_tuser  = r_out.status;

endmodule

// ===== rtl/smpq_store.sv =====
// Entry store of the sorted max priority queue: one write port, one read port.
// Read data is registered. Depends on smpq_pkg.
module smpq_store
    import smpq_pkg::*;
(
    input  logic      i_clk,
    input  t_mem_req  i_req,
    output t_data     o_rd_data
);

    t_data r_mem [CAPACITY];
    t_data r_rd_data;

    // Write and registered read; a read of the address being written sees the old word.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/smpq_seq.sv =====
// Sequencer of the sorted max priority queue: walks the store one entry a cycle
// with a single signed compare unit. Depends on smpq_pkg, smpq_store and the defines header.
`include "sorted_max_priority_queue_top_defines.svh"

module smpq_seq
    import smpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_op,
    input  t_data    i_value,
    output logic     o_idle,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_EXT_TAKE = 3'd2;
    localparam logic [2:0] S_EXT_SH   = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    t_data               r_top, n_top;
    t_data               r_val, n_val;
    t_data               r_taken, n_taken;
    logic [STATUS_W-1:0] r_status, n_status;
    t_mem_req            mem_req;
    t_data               rd_data;
    logic                entry_gt;

    smpq_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // The shared compare unit: stored entry strictly above the value being placed.
    assign entry_gt = (rd_data > r_val);

    // Next-state logic of the sequencer and store access.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_count       = r_count;
        n_top         = r_top;
        n_val         = r_val;
        n_taken       = r_taken;
        n_status      = r_status;
        mem_req.we    = 1'b0;
        mem_req.waddr = r_idx;
        mem_req.wdata = r_val;
        mem_req.raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = i_value;
                    n_taken  = '0;
                    n_status = ST_OK;
                    if (i_op == OP_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_OVER;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = S_INS;
                        end else begin
                            // Start at the tail and move toward the head.
                            mem_req.raddr = IDX_W'(r_count - CNT_W'(1));
                            n_idx         = IDX_W'(r_count);
                            n_state       = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_UNDER;
                            n_state  = S_DONE;
                        end else begin
                            mem_req.raddr = '0;
                            n_state       = S_EXT_TAKE;
                        end
                    end
                end
            end
            S_INS: begin
                if (r_idx == '0) begin
                    // New value becomes the head, ahead of any equals.
                    mem_req.we    = 1'b1;
                    mem_req.wdata = r_val;
                    n_top         = r_val;
                    n_count       = r_count + CNT_W'(1);
                    n_state       = S_DONE;
                end else if (entry_gt) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = r_val;
                    n_count       = r_count + CNT_W'(1);
                    n_state       = S_DONE;
                end else begin
                    // Move the smaller or equal entry one slot down.
                    mem_req.we    = 1'b1;
                    mem_req.wdata = rd_data;
                    mem_req.raddr = r_idx - 1'b1 - 1'b1;
                    n_idx         = r_idx - 1'b1;
                end
            end
            S_EXT_TAKE: begin
                n_taken = rd_data;
                if (r_count == CNT_W'(1)) begin
                    n_count = '0;
                    n_top   = '0;
                    n_state = S_DONE;
                end else begin
                    mem_req.raddr = IDX_W'(1);
                    n_idx         = IDX_W'(1);
                    n_state       = S_EXT_SH;
                end
            end
            S_EXT_SH: begin
                // Move each remaining entry one slot up.
                mem_req.we    = 1'b1;
                mem_req.waddr = r_idx - 1'b1;
                mem_req.wdata = rd_data;
                if (r_idx == IDX_W'(1)) begin
                    n_top = rd_data;
                end
                if ((CNT_W'(r_idx) + CNT_W'(1)) < r_count) begin
                    mem_req.raddr = r_idx + 1'b1;
                    n_idx         = r_idx + 1'b1;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_taken  <= n_taken;
        r_status <= n_status;
    end

    assign o_idle            = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.taken_value = r_taken;
    assign o_res.top_value   = r_top;
    assign o_res.entry_count = r_count;
    assign o_res.status      = r_status;

    // Checks on the sequencer's own bookkeeping.
    `SMPQ_CHECK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `SMPQ_IMPLY(a_empty_top, i_clk, i_rst_n, r_count == '0, r_top == '0, "empty queue with nonzero top")
    `SMPQ_IMPLY(a_over_full, i_clk, i_rst_n, (r_state == S_DONE) && (r_status == ST_OVER), r_count == CNT_W'(CAPACITY), "overflow reported while not full")
    `SMPQ_IMPLY(a_under_empty, i_clk, i_rst_n, (r_state == S_DONE) && (r_status == ST_UNDER), (r_count == '0) && (r_taken == '0), "underflow reported while not empty")
    `SMPQ_IMPLY(a_write_busy, i_clk, i_rst_n, mem_req.we, (r_state != S_IDLE) && (r_state != S_DONE), "store written outside an operation")

endmodule

// ===== tb/smpq_result_checker.sv =====
// Result checker for the sorted max priority queue: watches both stream channels,
// keeps its own sorted copy of the queue and compares every result word with it.
// Depends on smpq_pkg for sizes, operation codes, status codes and the result type.
module smpq_result_checker
    import smpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [0:0]  i_s_tuser,   // [0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // [31:0] taken_value, [63:32] top_value,
                                     // [68:64] entry_count, [71:69] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_mismatch_count,
    output int          o_results_due
);

    // Own copy of the queue contents, largest value first.
    t_data   held_values [CAPACITY];
    int      held_count;
    t_result results_ahead [$];
    int      mismatches;

    initial begin
        held_count       = 0;
        mismatches       = 0;
        o_mismatch_count = 0;
        o_results_due    = 0;
    end

    // Applies one accepted word to the held queue and returns the result it yields.
    function automatic t_result apply_queue_op(input logic op, input t_data val);
        t_result res;
        int      slot;
        int      k;
        res = '0;
        if (op == OP_INSERT) begin
            if (held_count >= CAPACITY) begin
                res.status = ST_OVER;
            end else begin
                // A new value goes ahead of every stored value equal to it.
                slot = 0;
                while (slot < held_count && val < held_values[slot]) begin
                    slot++;
                end
                for (k = held_count; k > slot; k--) begin
                    held_values[k] = held_values[k-1];
                end
                held_values[slot] = val;
                held_count++;
                res.status = ST_OK;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_UNDER;
            end else begin
                res.taken_value = held_values[0];
                for (k = 1; k < held_count; k++) begin
                    held_values[k-1] = held_values[k];
                end
                held_count--;
                res.status = ST_OK;
            end
        end
        res.top_value   = (held_count > 0) ? held_values[0] : '0;
        res.entry_count = CNT_W'(held_count);
        return res;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
        end
    endtask

    // Record each accepted input word and check each accepted result word.
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            held_count = 0;
            results_ahead.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                results_ahead.push_back(apply_queue_op(i_s_tuser[0], i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (results_ahead.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, got %h / %h",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    want = results_ahead.pop_front();
                    check_field("taken_value", want.taken_value, i_m_tdata[31:0]);
                    check_field("top_value", want.top_value, i_m_tdata[63:32]);
                    check_field("entry_count", 32'(want.entry_count), 32'(i_m_tdata[68:64]));
                    check_field("tdata padding", 32'd0, 32'(i_m_tdata[71:69]));
                    check_field("status", 32'(want.status), 32'(i_m_tuser));
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_results_due    <= results_ahead.size();
    end

endmodule

// ===== tb/tb_sorted_max_priority_queue_top.sv =====
// Testbench top for the sorted max priority queue: clock, reset, input words and
// result back-pressure, with the verdict. Depends on smpq_pkg, the block under
// test and smpq_result_checker, which does all prediction and comparison.
module tb_sorted_max_priority_queue_top;
    import smpq_pkg::*;

    typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} t_pace;

    localparam int RANDOM_WORDS  = 385;
    localparam int BURST_LEN     = 40;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 4000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;
    wire  [1:0]  m_tuser;
    int          mismatch_count;
    int          results_due;
    int          gap_pct   = 0;
    int          stall_pct = 0;

    always #2 clk = ~clk;

    sorted_max_priority_queue_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    smpq_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    // Result back-pressure: stall at random at the rate the current pace sets.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #2000000;
        $display("tb_sorted_max_priority_queue_top: FAIL");
        $finish;
    end

    task automatic set_pace(input t_pace pace);
        gap_pct   = (pace == PACE_SENDER) ? 46 : (pace == PACE_BOTH) ? 6 : 0;
        stall_pct = (pace == PACE_RECEIVER) ? 46 : (pace == PACE_BOTH) ? 6 : 0;
    endtask

    // Offers one word, after a random idle gap, and returns once it is accepted.
    task automatic send_word(input logic op, input logic [31:0] val);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= val;
        s_tuser[0] <= op;
        do begin
            @(posedge clk);
        end while (!s_tready);
    endtask

    // Holds the input idle until every outstanding result word has come out, or until DRAIN_LIMIT is reached.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge clk);
            waited++;
        end while (results_due != 0 && waited < DRAIN_LIMIT);
    endtask

    // Values mix full-range noise, a narrow band that gives many equals, and
    // values at or near both ends of the signed range.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($urandom_range(8)) - 32'd4;
            2: begin
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return ($urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0000)
                            | 32'($urandom_range(255));
        endcase
    endfunction

    // Bursts lean toward inserts or extracts so the queue sweeps between
    // empty and full, hitting underflow and overflow along the way.
    task automatic run_random(input int count);
        int insert_pct;
        insert_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % BURST_LEN == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            send_word(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
                      pick_value());
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extract when empty, both ends of the range, equal to the head,
        // filling to capacity, insert when full, then shifts at full depth.
        send_word(OP_EXTRACT, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 32'h0000_0000);
        send_word(OP_INSERT, 32'h8000_0000);
        send_word(OP_INSERT, 32'h7FFF_FFFF);
        send_word(OP_INSERT, 32'h7FFF_FFFF);
        send_word(OP_INSERT, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 32'hAAAA_AAAA);
        send_word(OP_INSERT, 32'h5555_5555);
        repeat (9) send_word(OP_INSERT, pick_value());
        send_word(OP_INSERT, 32'h1234_5678);
        send_word(OP_EXTRACT, 32'h0000_0000);
        send_word(OP_INSERT, 32'h7FFF_FFFF);
        send_word(OP_EXTRACT, 32'h0000_0000);
        wait_for_drain();

        // Random phases, one per pacing pattern, each ending with a full drain.
        set_pace(PACE_FREE);
        run_random(RANDOM_WORDS);
        wait_for_drain();
        set_pace(PACE_SENDER);
        run_random(RANDOM_WORDS);
        wait_for_drain();
        set_pace(PACE_RECEIVER);
        run_random(RANDOM_WORDS);
        wait_for_drain();
        set_pace(PACE_BOTH);
        run_random(RANDOM_WORDS);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("tb_sorted_max_priority_queue_top: PASS");
        end else begin
            $display("tb_sorted_max_priority_queue_top: FAIL");
        end
        $finish;
    end

endmodule
